// File: rtl/core/dcs_pkg.sv
package dcs_pkg;

   localparam int NumDigits = 4;

   typedef logic [6:0]           segments_type;
   typedef logic [NumDigits-1:0] enables_type;
   typedef logic [$clog2(NumDigits)-1:0] digit_index_type;
   typedef logic [4:0]           hours_type;
   typedef logic [5:0]           sixty_type;
   typedef logic [9:0]           period10_type;
   typedef logic [7:0]           period8_type;
   typedef logic [1:0]           csr_index_type;
   typedef logic [9:0]           csr_data_type;
   typedef logic [3:0]           bcd_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CsrTicksPerSecond = 2'd0;
   localparam csr_index_type CsrScanPeriod     = 2'd1;
   localparam csr_index_type CsrBlinkPeriod    = 2'd2;

   localparam period10_type ResetTicksPerSecond = 10'd100;
   localparam period8_type  ResetScanPeriod     = 8'd25;
   localparam period10_type ResetBlinkPeriod    = 10'd100;

   localparam hours_type    ResetHours   = 5'd15;
   localparam sixty_type    ResetMinutes = 6'd8;
   localparam sixty_type    ResetSeconds = 6'd54;
   localparam segments_type ResetSegments = 7'd121;
   localparam enables_type  ResetEnables  = 4'd14;

   localparam sixty_type  SixtyLimit = 6'd60;
   localparam hours_type  DayLimit   = 5'd24;

   // Lit segments of the decimal digits, bit 0 is segment a.
   localparam segments_type SegLit [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   typedef struct packed {
      hours_type hours;
      sixty_type minutes;
      sixty_type seconds;
   } time_type;

   typedef struct packed {
      segments_type segments;
      enables_type  enables;
      logic         blink;
   } display_type;

   function automatic bcd_type tens_of(input sixty_type v);
      bcd_type t;
      if (v >= 6'd50) begin
         t = 4'd5;
      end else if (v >= 6'd40) begin
         t = 4'd4;
      end else if (v >= 6'd30) begin
         t = 4'd3;
      end else if (v >= 6'd20) begin
         t = 4'd2;
      end else if (v >= 6'd10) begin
         t = 4'd1;
      end else begin
         t = 4'd0;
      end
      return t;
   endfunction

   function automatic bcd_type units_of(input sixty_type v);
      sixty_type t;
      sixty_type r;
      t = {2'b00, tens_of(v)};
      r = v - {t[2:0], 3'b000} - {t[4:0], 1'b0};
      return r[3:0];
   endfunction

   // Active-low pattern; codes above nine blank the digit.
   function automatic segments_type pattern_of(input bcd_type d);
      segments_type p;
      if (d > 4'd9) begin
         p = 7'h7F;
      end else begin
         p = ~SegLit[d];
      end
      return p;
   endfunction

endpackage

// File: rtl/core/dcs_channels.sv
interface dcs_req_if;
   logic valid;
   logic ready;
   logic tick;

   modport source (output valid, output tick, input ready);
   modport sink   (input valid, input tick, output ready);
endinterface

interface dcs_rsp_if import dcs_pkg::*; ;
   logic         valid;
   logic         ready;
   segments_type segments;
   enables_type  digit_enables;
   logic         dot_out;
   logic         status_led;
   hours_type    hours_now;
   sixty_type    minutes_now;
   sixty_type    seconds_now;

   modport source (output valid, output segments, output digit_enables, output dot_out,
                   output status_led, output hours_now, output minutes_now,
                   output seconds_now, input ready);
   modport sink   (input valid, input segments, input digit_enables, input dot_out,
                   input status_led, input hours_now, input minutes_now,
                   input seconds_now, output ready);
endinterface

interface dcs_csr_if import dcs_pkg::*; ;
   logic          valid;
   logic          ready;
   csr_index_type reg_index;
   csr_data_type  wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/core/digital_clock_seven_segment_scan.sv
// Multiplexed seven-segment 24-hour clock driven by base ticks.
// Input channel req_chan carries one tick bit per transfer; a one advances
// the second prescaler, the digit scan counter and the blink counter, a zero
// leaves every counter as it is. Each input transfer yields exactly one
// result on rsp_chan: the latched active-low segments and digit enables, the
// dot and status LED level, and the current hours, minutes and seconds.
// The result is in the output register in the cycle after the input
// transfer. Throughput is one item per cycle, limited only by the single
// output register, which accepts a new item in the same cycle that its
// current result is taken.
// When the receiver stalls, the output register holds its result and
// req_chan.ready drops until the result is taken; no item is lost.
// The csr_chan port writes ticks_per_second (index 0), scan_period (1) and
// blink_period (2); it is always ready and an unknown index is ignored.
// Reset is synchronous: the time returns to 15:08:54, the registers to their
// defaults, the first digit is selected and no result is pending.
module digital_clock_seven_segment_scan import dcs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   dcs_req_if.sink  req_chan,
   dcs_rsp_if.source rsp_chan,
   dcs_csr_if.sink  csr_chan
);

   period10_type tps_ff, blink_period_ff;
   period8_type  scan_period_ff;
   logic         accept;
   logic         step;
   time_type     time_in;
   display_type  display_in;

   logic         rsp_valid_ff;
   time_type     time_ff;
   display_type  display_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff          <= ResetTicksPerSecond;
         scan_period_ff  <= ResetScanPeriod;
         blink_period_ff <= ResetBlinkPeriod;
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CsrTicksPerSecond: tps_ff          <= csr_chan.wr_data;
            CsrScanPeriod:     scan_period_ff  <= csr_chan.wr_data[7:0];
            CsrBlinkPeriod:    blink_period_ff <= csr_chan.wr_data;
            default:           ;
         endcase
      end
   end

   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign accept         = req_chan.valid & req_chan.ready;
   assign step           = accept & req_chan.tick;

   dcs_time u_time (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .ticks_per_second (tps_ff),
      .time_in          (time_in)
   );

   dcs_display u_display (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .scan_period  (scan_period_ff),
      .blink_period (blink_period_ff),
      .time_in      (time_in),
      .display_in   (display_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         time_ff    <= time_in;
         display_ff <= display_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.segments      = display_ff.segments;
   assign rsp_chan.digit_enables = display_ff.enables;
   assign rsp_chan.dot_out       = display_ff.blink;
   assign rsp_chan.status_led    = display_ff.blink;
   assign rsp_chan.hours_now     = time_ff.hours;
   assign rsp_chan.minutes_now   = time_ff.minutes;
   assign rsp_chan.seconds_now   = time_ff.seconds;

endmodule

// File: rtl/core/dcs_time.sv
module dcs_time import dcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  period10_type ticks_per_second,
   output time_type     time_in
);

   period10_type prescale_ff, prescale_in;
   hours_type    hours_ff;
   sixty_type    minutes_ff, seconds_ff;
   hours_type    hours_next;
   sixty_type    minutes_next, seconds_next;

   always_comb begin
      prescale_in  = prescale_ff;
      hours_next   = hours_ff;
      minutes_next = minutes_ff;
      seconds_next = seconds_ff;
      if (step) begin
         if (prescale_ff <= 10'd1) begin
            prescale_in  = ticks_per_second;
            seconds_next = seconds_ff + 6'd1;
            if (seconds_next >= SixtyLimit) begin
               seconds_next = '0;
               minutes_next = minutes_ff + 6'd1;
            end
            if (minutes_next >= SixtyLimit) begin
               minutes_next = '0;
               hours_next   = hours_ff + 5'd1;
            end
            if (hours_next >= DayLimit) begin
               hours_next = '0;
            end
         end else begin
            prescale_in = prescale_ff - 10'd1;
         end
      end
   end

   assign time_in = '{hours: hours_next, minutes: minutes_next, seconds: seconds_next};

   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= ResetTicksPerSecond;
         hours_ff    <= ResetHours;
         minutes_ff  <= ResetMinutes;
         seconds_ff  <= ResetSeconds;
      end else begin
         prescale_ff <= prescale_in;
         hours_ff    <= hours_next;
         minutes_ff  <= minutes_next;
         seconds_ff  <= seconds_next;
      end
   end

endmodule

// File: rtl/core/dcs_display.sv
module dcs_display import dcs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  period8_type  scan_period,
   input  period10_type blink_period,
   input  time_type     time_in,
   output display_type  display_in
);

   period8_type     scan_ff, scan_in;
   digit_index_type digit_ff, digit_in;
   digit_index_type digit_next;
   period10_type    blink_count_ff, blink_count_in;
   logic            blink_ff, blink_in;
   segments_type    segments_ff, segments_in;
   enables_type     enables_ff, enables_in;
   bcd_type         digit_value;
   sixty_type       hours_wide;

   assign hours_wide = {1'b0, time_in.hours};
   assign digit_next = digit_ff + 1'b1;

   // The digit picked up uses the time as it stands after this transfer.
   always_comb begin
      case (digit_next)
         2'd0:    digit_value = tens_of(hours_wide);
         2'd1:    digit_value = units_of(hours_wide);
         2'd2:    digit_value = tens_of(time_in.minutes);
         default: digit_value = units_of(time_in.minutes);
      endcase
   end

   always_comb begin
      scan_in        = scan_ff;
      digit_in       = digit_ff;
      segments_in    = segments_ff;
      enables_in     = enables_ff;
      blink_count_in = blink_count_ff;
      blink_in       = blink_ff;
      if (step) begin
         if (scan_ff <= 8'd1) begin
            scan_in     = scan_period;
            digit_in    = digit_next;
            segments_in = pattern_of(digit_value);
            enables_in  = ~(enables_type'(1) << digit_next);
         end else begin
            scan_in = scan_ff - 8'd1;
         end
         if (blink_count_ff <= 10'd1) begin
            blink_count_in = blink_period;
            blink_in       = ~blink_ff;
         end else begin
            blink_count_in = blink_count_ff - 10'd1;
         end
      end
   end

   assign display_in = '{segments: segments_in, enables: enables_in, blink: blink_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff        <= ResetScanPeriod;
         digit_ff       <= '0;
         segments_ff    <= ResetSegments;
         enables_ff     <= ResetEnables;
         blink_count_ff <= ResetBlinkPeriod;
         blink_ff       <= 1'b1;
      end else begin
         scan_ff        <= scan_in;
         digit_ff       <= digit_in;
         segments_ff    <= segments_in;
         enables_ff     <= enables_in;
         blink_count_ff <= blink_count_in;
         blink_ff       <= blink_in;
      end
   end

endmodule

// File: rtl/core/dcs_checker.sv
module dcs_checker import dcs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input segments_type segments,
   input enables_type  digit_enables,
   input logic         dot_out,
   input logic         status_led,
   input hours_type    hours_now,
   input sixty_type    minutes_now,
   input sixty_type    seconds_now
);

   // Every accepted transfer leaves a result in the output register.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   // The input side may only stall while a result is waiting.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without a waiting result");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(~digit_enables) && dot_out == status_led)
      else $error("digit enables or blink outputs inconsistent");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> hours_now < DayLimit && minutes_now < SixtyLimit
                    && seconds_now < SixtyLimit)
      else $error("time of day out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(segments)
                                  && $stable(seconds_now))
      else $error("stalled result changed");

endmodule

bind digital_clock_seven_segment_scan dcs_checker u_dcs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .segments      (rsp_chan.segments),
   .digit_enables (rsp_chan.digit_enables),
   .dot_out       (rsp_chan.dot_out),
   .status_led    (rsp_chan.status_led),
   .hours_now     (rsp_chan.hours_now),
   .minutes_now   (rsp_chan.minutes_now),
   .seconds_now   (rsp_chan.seconds_now)
);

// File: bench/testbench.sv
module testbench;
   import dcs_pkg::*;

   // Index that decodes to no register; writes to it must leave everything as it was.
   localparam csr_index_type CsrUnused = 2'd3;

   typedef struct {
      segments_type segments;
      enables_type  enables;
      logic         blink;
      hours_type    hours;
      sixty_type    minutes;
      sixty_type    seconds;
   } clock_view_type;

   class clock_scoreboard_type;
      period10_type    tps_reg;
      period8_type     scan_reg;
      period10_type    blink_reg;
      hours_type       hours;
      sixty_type       minutes;
      sixty_type       seconds;
      period10_type    second_count;
      period8_type     scan_count;
      period10_type    blink_count;
      digit_index_type digit;
      logic            blink;
      segments_type    seg_latch;
      enables_type     en_latch;
      clock_view_type  expected_views[$];
      int unsigned     errors;

      function new();
         tps_reg      = ResetTicksPerSecond;
         scan_reg     = ResetScanPeriod;
         blink_reg    = ResetBlinkPeriod;
         hours        = ResetHours;
         minutes      = ResetMinutes;
         seconds      = ResetSeconds;
         second_count = ResetTicksPerSecond;
         scan_count   = ResetScanPeriod;
         blink_count  = ResetBlinkPeriod;
         digit        = '0;
         blink        = 1'b1;
         seg_latch    = ResetSegments;
         en_latch     = ResetEnables;
         errors       = 0;
      endfunction

      function int pending();
         return expected_views.size();
      endfunction

      function void write_reg(csr_index_type idx, csr_data_type data);
         case (idx)
            CsrTicksPerSecond: tps_reg = data;
            CsrScanPeriod: scan_reg = data[7:0];
            CsrBlinkPeriod: blink_reg = data;
            default: ;
         endcase
      endfunction

      // Advances the clock by one accepted input and queues the display it should produce.
      function void note_tick(logic t);
         clock_view_type view;
         bcd_type        shown;
         if (t) begin
            // The time is updated before the scan, so a fresh digit shows the new time.
            if (second_count <= 1) begin
               second_count = tps_reg;
               seconds = seconds + 6'd1;
               if (seconds >= SixtyLimit) begin
                  seconds = '0;
                  minutes = minutes + 6'd1;
               end
               if (minutes >= SixtyLimit) begin
                  minutes = '0;
                  hours = hours + 5'd1;
               end
               if (hours >= DayLimit) begin
                  hours = '0;
               end
            end else begin
               second_count = second_count - 10'd1;
            end
            if (scan_count <= 1) begin
               scan_count = scan_reg;
               digit = digit + 2'd1;
               case (digit)
                  2'd0: shown = bcd_type'(hours / 10);
                  2'd1: shown = bcd_type'(hours % 10);
                  2'd2: shown = bcd_type'(minutes / 10);
                  default: shown = bcd_type'(minutes % 10);
               endcase
               seg_latch = ~SegLit[shown];
               en_latch = ~(enables_type'(1) << digit);
            end else begin
               scan_count = scan_count - 8'd1;
            end
            if (blink_count <= 1) begin
               blink_count = blink_reg;
               blink = ~blink;
            end else begin
               blink_count = blink_count - 10'd1;
            end
         end
         view.segments = seg_latch;
         view.enables  = en_latch;
         view.blink    = blink;
         view.hours    = hours;
         view.minutes  = minutes;
         view.seconds  = seconds;
         expected_views.push_back(view);
      endfunction

      task report(string line);
         $display("MISMATCH at %0t: %s", $realtime, line);
         errors++;
      endtask

      task compare_field(string name, int unsigned seen, int unsigned want);
         if (seen != want) begin
            report($sformatf("%s is %0d, expected %0d", name, seen, want));
         end
      endtask

      task check_result(clock_view_type seen, logic status_led);
         clock_view_type want;
         if (expected_views.size() == 0) begin
            report("result transfer with nothing expected");
         end else begin
            want = expected_views.pop_front();
            compare_field("segments", seen.segments, want.segments);
            compare_field("digit_enables", seen.enables, want.enables);
            compare_field("dot_out", seen.blink, want.blink);
            compare_field("status_led", status_led, want.blink);
            compare_field("hours_now", seen.hours, want.hours);
            compare_field("minutes_now", seen.minutes, want.minutes);
            compare_field("seconds_now", seen.seconds, want.seconds);
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   quiet_mode = 1'b0;
   int   stall_left = 0;

   clock_scoreboard_type sb = new();

   dcs_req_if req_chan ();
   dcs_rsp_if rsp_chan ();
   dcs_csr_if csr_chan ();

   digital_clock_seven_segment_scan u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(20_000_000);
      $display("CHECKS FAILED");
      $finish;
   end

   // Result side: random bursts of back-pressure, none once the run goes quiet.
   always @(negedge clock) begin
      if (quiet_mode) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 6) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_monitor
      clock_view_type seen;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen.segments = rsp_chan.segments;
         seen.enables  = rsp_chan.digit_enables;
         seen.blink    = rsp_chan.dot_out;
         seen.hours    = rsp_chan.hours_now;
         seen.minutes  = rsp_chan.minutes_now;
         seen.seconds  = rsp_chan.seconds_now;
         sb.check_result(seen, rsp_chan.status_led);
      end
   end

   task automatic push_tick(logic t);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 6)) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_chan.valid <= 1'b1;
      req_chan.tick  <= t;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_tick(t);
   endtask

   task automatic write_csr(csr_index_type idx, csr_data_type data);
      @(negedge clock);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.wr_data   <= data;
      do @(posedge clock); while (!csr_chan.ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // Stops the input side and waits until every queued display has been seen.
   task automatic settle();
      int waited;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      waited = 0;
      while (sb.pending() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.pending()));
         sb.expected_views.delete();
      end
      repeat (3) @(posedge clock);
   endtask

   function automatic csr_data_type pick_period();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 10'h3FF;
         2, 3: return csr_data_type'($urandom_range(1, 8));
         default: return csr_data_type'($urandom_range(0, 1023));
      endcase
   endfunction

   initial begin : stimulus
      int phase;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.tick      = 1'b0;
      rsp_chan.ready     = 1'b0;
      csr_chan.valid     = 1'b0;
      csr_chan.reg_index = CsrTicksPerSecond;
      csr_chan.wr_data   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default settings straight out of reset, with idle inputs mixed in.
      push_tick(1'b0);
      push_tick(1'b1);
      push_tick(1'b0);
      push_tick(1'b1);

      // Zero scan and blink periods: once their counters reload, both act on every tick.
      settle();
      write_csr(CsrTicksPerSecond, 10'h3FF);
      write_csr(CsrScanPeriod, '0);
      write_csr(CsrBlinkPeriod, '0);
      repeat (4) push_tick(1'b1);

      // A zero second period takes hold at the next prescaler reload; the scan register
      // keeps only its low byte, and the unused index must change nothing.
      settle();
      write_csr(CsrTicksPerSecond, '0);
      write_csr(CsrScanPeriod, 10'h3FF);
      write_csr(CsrBlinkPeriod, 10'd1);
      write_csr(CsrUnused, 10'h3FF);
      repeat (7) push_tick(1'b1);

      settle();
      write_csr(CsrTicksPerSecond, 10'd1);
      write_csr(CsrScanPeriod, 10'd1);
      write_csr(CsrBlinkPeriod, 10'h3FF);
      push_tick(1'b1);
      push_tick(1'b0);
      push_tick(1'b1);
      push_tick(1'b1);

      for (phase = 0; phase < 12; phase++) begin
         settle();
         write_csr(CsrTicksPerSecond, pick_period());
         write_csr(CsrScanPeriod, pick_period());
         write_csr(CsrBlinkPeriod, pick_period());
         if ($urandom_range(0, 2) == 0) begin
            write_csr(CsrUnused, csr_data_type'($urandom_range(0, 1023)));
         end
         repeat (65) push_tick($urandom_range(0, 7) != 0);
      end

      // One second per tick once the prescaler reloads, at full rate with no idling.
      settle();
      quiet_mode = 1'b1;
      write_csr(CsrTicksPerSecond, 10'd1);
      write_csr(CsrScanPeriod, pick_period());
      write_csr(CsrBlinkPeriod, pick_period());
      repeat (100) push_tick($urandom_range(0, 19) != 0);
      settle();

      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/dcs_pkg.sv
rtl/core/dcs_channels.sv
rtl/core/dcs_time.sv
rtl/core/dcs_display.sv
rtl/core/digital_clock_seven_segment_scan.sv
rtl/core/dcs_checker.sv
bench/testbench.sv
